@@ sv/ffa_pkg.sv @@
// Shared types and constants of the free-list allocator.
package ffa_pkg;

   // Width of a stored link or size field, and of a unit index with carry
   localparam int FIELD_W = 12;
   localparam int INDEX_W = 13;
   localparam int UNITS_W = 13;
   localparam int BYTES_W = 15;

   // Request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Register index of heap_units
   localparam logic REG_HEAP_UNITS = 1'b0;

   // Lowest unit count ever used for the heap
   localparam logic [UNITS_W-1:0] MIN_UNITS = 13'd3;

   typedef struct packed {
      logic               mode;
      logic [BYTES_W-1:0] request_bytes;
      logic [FIELD_W-1:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] payload_addr;
      logic               granted;
   } rsp_type;

   // Write command to the header store
   typedef struct packed {
      logic               next_en;
      logic               size_en;
      logic [INDEX_W-1:0] idx;
      logic [FIELD_W-1:0] next_val;
      logic [FIELD_W-1:0] size_val;
   } mem_wr_type;

endpackage

@@ sv/first_fit_free_list_allocator.sv @@
// Top level: free-list allocator sequencer over the header store.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+---------------------------
//   request  | start, busy, req_data                  | transfer when start & !busy
//   result   | rsp_valid, rsp_data                    | one-cycle strobe, no stall
//   config   | psel penable pwrite paddr pwdata prdata | APB, pready always high
//
// An allocation walks the free list, one memory read per block, with a split
// step when a block is split; a free walks it too, then merges neighbours.
// The walk sets the pace. The first request builds the list first. Reset is
// synchronous; the store keeps its contents, and in the sequencer the state,
// result strobe, list-built flag and rover clear. Results cannot be stalled.
module first_fit_free_list_allocator #(
   parameter int HEAP_UNITS = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ffa_pkg::req_type req_data,
   output logic             rsp_valid,
   output ffa_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int DEPTH = (HEAP_UNITS < 8192) ? HEAP_UNITS : 8192;
   localparam int CAP   = (HEAP_UNITS < 4096) ? HEAP_UNITS : 4096;
   localparam int SW    = $clog2(HEAP_UNITS + 2);
   localparam int FW    = ffa_pkg::FIELD_W;
   localparam int IW    = ffa_pkg::INDEX_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BUILD0 = 4'd1;
   localparam logic [3:0] S_BUILD1 = 4'd2;
   localparam logic [3:0] S_DISP   = 4'd3;
   localparam logic [3:0] S_AHEAD  = 4'd4;
   localparam logic [3:0] S_AWALK  = 4'd5;
   localparam logic [3:0] S_ASPLIT = 4'd6;
   localparam logic [3:0] S_FWALK  = 4'd7;
   localparam logic [3:0] S_FRB    = 4'd8;
   localparam logic [3:0] S_FRN    = 4'd9;
   localparam logic [3:0] S_FWP    = 4'd10;

   logic [3:0]                  state_ff, state_in;
   ffa_pkg::req_type            req_ff, req_in;
   logic                        built_ff, built_in;
   logic [FW-1:0]               rover_ff, rover_in;
   logic [FW-1:0]               prev_ff, prev_in;
   logic [FW-1:0]               p_ff, p_in;
   logic [SW-1:0]               steps_ff, steps_in;
   logic [IW-1:0]               need_ff, need_in;
   logic [IW-1:0]               p2_ff, p2_in;
   logic [FW-1:0]               nx_ff, nx_in;
   logic [FW-1:0]               sp_ff, sp_in;
   logic [FW-1:0]               sb_ff, sb_in;
   logic [FW-1:0]               nsb_ff, nsb_in;
   logic [FW-1:0]               nnb_ff, nnb_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ffa_pkg::rsp_type            rsp_ff, rsp_in;

   logic [ffa_pkg::UNITS_W-1:0] heap_units;
   logic [ffa_pkg::UNITS_W-1:0] units;
   logic [IW-1:0]               rd_idx;
   ffa_pkg::mem_wr_type         wr;
   logic [FW-1:0]               m_next, m_size;
   logic [FW-1:0]               bp;
   logic [IW-1:0]               rem;
   logic [FW-1:0]               sp_cur;
   logic                        found;

   ffa_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .heap_units (heap_units)
   );

   ffa_heap_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .wr      (wr),
      .rd_next (m_next),
      .rd_size (m_size)
   );

   // Clamp the unit count to the usable range
   always_comb begin
      units = heap_units;
      if (units < ffa_pkg::MIN_UNITS) begin
         units = ffa_pkg::MIN_UNITS;
      end
      if (32'(units) > CAP) begin
         units = ffa_pkg::UNITS_W'(CAP);
      end
   end

   assign bp  = req_ff.block_addr - 12'd1;
   assign rem = {1'b0, m_size} - need_ff;
   assign found = ((bp > p_ff) && (bp < m_next)) ||
                  ((p_ff >= m_next) && ((bp > p_ff) || (bp < m_next)));
   assign sp_cur = (p_ff == bp) ? nsb_ff : sp_ff;

   // Sequence build, walk and header updates
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      built_in     = built_ff;
      rover_in     = rover_ff;
      prev_in      = prev_ff;
      p_in         = p_ff;
      steps_in     = steps_ff;
      need_in      = need_ff;
      p2_in        = p2_ff;
      nx_in        = nx_ff;
      sp_in        = sp_ff;
      sb_in        = sb_ff;
      nsb_in       = nsb_ff;
      nnb_in       = nnb_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_idx       = '0;
      wr           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = built_ff ? S_DISP : S_BUILD0;
            end
         end
         S_BUILD0: begin
            // Sentinel at unit 0 links to unit 1
            wr.next_en  = 1'b1;
            wr.size_en  = 1'b1;
            wr.idx      = '0;
            wr.next_val = 12'd1;
            wr.size_val = '0;
            state_in    = S_BUILD1;
         end
         S_BUILD1: begin
            // One block spanning the heap links back to the sentinel
            wr.next_en  = 1'b1;
            wr.size_en  = 1'b1;
            wr.idx      = 13'd1;
            wr.next_val = '0;
            wr.size_val = FW'(units - 13'd1);
            rover_in    = '0;
            built_in    = 1'b1;
            state_in    = S_DISP;
         end
         S_DISP: begin
            rd_idx   = IW'(rover_ff);
            steps_in = '0;
            p_in     = rover_ff;
            need_in  = IW'((({1'b0, req_ff.request_bytes} + 16'd7) >> 3) + 16'd1);
            if (req_ff.mode == ffa_pkg::MODE_ALLOC) begin
               if (req_ff.request_bytes == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_AHEAD;
               end
            end else begin
               if ((req_ff.block_addr < 12'd2) || ({1'b0, bp} >= units)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_FWALK;
               end
            end
         end
         S_AHEAD: begin
            prev_in  = rover_ff;
            p_in     = m_next;
            rd_idx   = IW'(m_next);
            state_in = S_AWALK;
         end
         S_AWALK: begin
            priority if (32'(steps_ff) > HEAP_UNITS) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = S_IDLE;
            end else if ({1'b0, m_size} == need_ff) begin
               // Exact fit: unlink the block
               wr.next_en   = 1'b1;
               wr.idx       = IW'(prev_ff);
               wr.next_val  = m_next;
               rover_in     = prev_ff;
               rsp_valid_in = 1'b1;
               rsp_in.payload_addr = p_ff + 12'd1;
               rsp_in.granted      = 1'b1;
               state_in     = S_IDLE;
            end else if ({1'b0, m_size} > need_ff) begin
               // Larger block: shrink it and hand out its tail
               wr.size_en  = 1'b1;
               wr.idx      = IW'(p_ff);
               wr.size_val = rem[FW-1:0];
               p2_in       = IW'(p_ff) + rem;
               state_in    = S_ASPLIT;
            end else if (p_ff == rover_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = S_IDLE;
            end else begin
               prev_in  = p_ff;
               p_in     = m_next;
               rd_idx   = IW'(m_next);
               steps_in = steps_ff + SW'(1);
            end
         end
         S_ASPLIT: begin
            wr.size_en   = 1'b1;
            wr.idx       = p2_ff;
            wr.size_val  = need_ff[FW-1:0];
            rover_in     = prev_ff;
            rsp_valid_in = 1'b1;
            rsp_in.payload_addr = p2_ff[FW-1:0] + 12'd1;
            rsp_in.granted      = 1'b1;
            state_in     = S_IDLE;
         end
         S_FWALK: begin
            priority if (32'(steps_ff) > HEAP_UNITS) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = S_IDLE;
            end else if (found) begin
               nx_in    = m_next;
               sp_in    = m_size;
               rd_idx   = IW'(bp);
               state_in = S_FRB;
            end else begin
               p_in     = m_next;
               rd_idx   = IW'(m_next);
               steps_in = steps_ff + SW'(1);
            end
         end
         S_FRB: begin
            sb_in    = m_size;
            rd_idx   = IW'(nx_ff);
            state_in = S_FRN;
         end
         S_FRN: begin
            // Merge with the upper neighbour when adjacent
            wr.next_en = 1'b1;
            wr.idx     = IW'(bp);
            if (({1'b0, bp} + {1'b0, sb_ff}) == {1'b0, nx_ff}) begin
               wr.size_en  = 1'b1;
               wr.size_val = sb_ff + m_size;
               wr.next_val = m_next;
               nsb_in      = sb_ff + m_size;
               nnb_in      = m_next;
            end else begin
               wr.next_val = nx_ff;
               nsb_in      = sb_ff;
               nnb_in      = nx_ff;
            end
            state_in = S_FWP;
         end
         S_FWP: begin
            // Merge with the lower neighbour when adjacent
            wr.next_en = 1'b1;
            wr.idx     = IW'(p_ff);
            if (({1'b0, p_ff} + {1'b0, sp_cur}) == {1'b0, bp}) begin
               wr.size_en  = 1'b1;
               wr.size_val = sp_cur + nsb_ff;
               wr.next_val = nnb_ff;
            end else begin
               wr.next_val = bp;
            end
            rover_in     = p_ff;
            rsp_valid_in = 1'b1;
            rsp_in.payload_addr = '0;
            rsp_in.granted      = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         built_ff     <= 1'b0;
         rover_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         rover_ff     <= rover_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance working registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      prev_ff  <= prev_in;
      p_ff     <= p_in;
      steps_ff <= steps_in;
      need_ff  <= need_in;
      p2_ff    <= p2_in;
      nx_ff    <= nx_in;
      sp_ff    <= sp_in;
      sb_ff    <= sb_in;
      nsb_ff   <= nsb_in;
      nnb_ff   <= nnb_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result is only given as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not start work");

   // Results never come back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // A refused request carries a null address
   a_null_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.granted) |-> (rsp_data.payload_addr == '0))
      else $error("failed request with non-null address");

endmodule

@@ sv/ffa_heap_mem.sv @@
// Header store: next-link and size memories with one read and one write port.
module ffa_heap_mem #(
   parameter int DEPTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ffa_pkg::INDEX_W-1:0]  rd_idx,
   input  ffa_pkg::mem_wr_type          wr,
   output logic [ffa_pkg::FIELD_W-1:0]  rd_next,
   output logic [ffa_pkg::FIELD_W-1:0]  rd_size
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ffa_pkg::FIELD_W-1:0] next_mem [DEPTH];
   logic [ffa_pkg::FIELD_W-1:0] size_mem [DEPTH];
   logic [ffa_pkg::FIELD_W-1:0] next_q_ff;
   logic [ffa_pkg::FIELD_W-1:0] size_q_ff;
   logic                        rd_ok_ff;
   logic                        rd_ok_in;
   logic                        wr_ok;

   // Indices beyond the store read as zero and drop writes
   assign rd_ok_in = 32'(rd_idx) < DEPTH;
   assign wr_ok    = 32'(wr.idx) < DEPTH;

   // Write the header fields
   always_ff @(posedge clock) begin
      if (wr.next_en && wr_ok) begin
         next_mem[wr.idx[AW-1:0]] <= wr.next_val;
      end
      if (wr.size_en && wr_ok) begin
         size_mem[wr.idx[AW-1:0]] <= wr.size_val;
      end
   end

   // Read the header fields, registered
   always_ff @(posedge clock) begin
      next_q_ff <= next_mem[rd_idx[AW-1:0]];
      size_q_ff <= size_mem[rd_idx[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff <= rd_ok_in;
      end
   end

   assign rd_next = rd_ok_ff ? next_q_ff : '0;
   assign rd_size = rd_ok_ff ? size_q_ff : '0;

endmodule

@@ sv/ffa_csr.sv @@
// Configuration register block holding heap_units.
module ffa_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output logic [ffa_pkg::UNITS_W-1:0] heap_units
);

   logic [ffa_pkg::UNITS_W-1:0] heap_units_ff;
   logic                        wr_hit;

   // Decode a completed write transfer to the register
   assign wr_hit = psel && penable && pwrite && (paddr[2] == ffa_pkg::REG_HEAP_UNITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_units_ff <= 13'd4096;
      end else if (wr_hit) begin
         heap_units_ff <= pwdata[ffa_pkg::UNITS_W-1:0];
      end
   end

   assign prdata     = (paddr[2] == ffa_pkg::REG_HEAP_UNITS) ? 32'(heap_units_ff) : '0;
   assign pready     = 1'b1;
   assign heap_units = heap_units_ff;

endmodule
